@@ hdl/mllt_pkg.sv @@
// Shared types, codes and sizes for the MAC learning limit table.
// No dependencies; every other file in hdl/ but mllt_ram refers to it by scoped names.
`default_nettype none

package mllt_pkg;

	localparam int MAX_VPORT_INDEX = 8192;
	localparam int RAM_DEPTH       = MAX_VPORT_INDEX + 1;
	localparam int RAM_AW          = $clog2(RAM_DEPTH);

	localparam logic [7:0] NO_LIMIT = 8'hff;

	// action codes
	localparam logic [2:0] ACT_LEARN  = 3'd0;
	localparam logic [2:0] ACT_AGE    = 3'd1;
	localparam logic [2:0] ACT_SETLIM = 3'd2;
	localparam logic [2:0] ACT_RESET  = 3'd3;
	localparam logic [2:0] ACT_FLUSH  = 3'd4;
	localparam logic [2:0] ACT_SETUP  = 3'd5;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_RANGE    = 3'd1;
	localparam logic [2:0] STAT_NOT_VLAN = 3'd2;
	localparam logic [2:0] STAT_DISABLED = 3'd3;
	localparam logic [2:0] STAT_LIMIT    = 3'd4;
	localparam logic [2:0] STAT_PENDING  = 3'd5;

	// learn mode commands
	localparam logic [1:0] MODE_NONE        = 2'd0;
	localparam logic [1:0] MODE_PEND_NO_FWD = 2'd1;
	localparam logic [1:0] MODE_PEND_FWD    = 2'd2;
	localparam logic [1:0] MODE_FWD_ONLY    = 2'd3;

	// alarm events
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic        is_vlan_port;
		logic [15:0] vp_index;
		logic        pending_flag;
		logic        move_flag;
		logic [7:0]  new_limit;
		logic [7:0]  intf_id;
		logic [11:0] tag_vid;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  learn_mode_cmd;
		logic [1:0]  alarm_event;
		logic [7:0]  alarm_intf;
		logic [11:0] alarm_vid;
		logic [7:0]  learned_count;
		logic [15:0] attempt_total;
	} rsp_t;

	// one table entry as stored in RAM
	typedef struct packed {
		logic [7:0]  learned;
		logic [15:0] total;
		logic [7:0]  limit;
		logic        raised;
		logic [7:0]  intf;
		logic [11:0] vid;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY_RESET = '{
		learned: 8'd0, total: 16'd0, limit: NO_LIMIT, raised: 1'b0,
		intf: 8'd0, vid: 12'd0
	};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic              clear;
		logic [RAM_AW-1:0] clr_addr;
		logic              capture;
		logic              exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/mac_learn_limit_table_core.sv @@
// MAC learning limit table core: one result beat per request beat.
// The accepting edge captures the request beat and reads its entry; the result
// is registered once the output register no longer holds a result not yet taken.
// One request at a time: the next is accepted only after the write-back of the
// updated entry on the single write port, which waits while the output is full.
// Reset: asynchronous; afterwards a clearing pass over all 8193 entries (one entry per
// cycle) writes every entry to its reset value while req_ready stays low.
// Depends on mllt_pkg, mllt_ctrl, mllt_dp, mllt_ram.
`default_nettype none

module mac_learn_limit_table_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output      logic            req_ready,
	input  wire mllt_pkg::req_t  req,
	output      logic            rsp_valid,
	input  wire logic            rsp_ready,
	output      mllt_pkg::rsp_t  rsp
);

	// Command and status between controller and datapath. The controller owns
	// the clear counter and sequencing; the datapath owns the entry RAM, the
	// captured request beat and the output register.
	mllt_pkg::ctrl_cmd_t cmd;
	mllt_pkg::dp_stat_t  stat;

	// Accept a beat only in idle, read the entry at the same edge, then
	// compute and write back once the output register can take the result.
	mllt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Output register lets a new request come in while the last result waits.
	mllt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// One request in flight: an accepted beat blocks the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one still executing");

	// An alarm start only comes with a limit-reached status.
	a_start_on_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.alarm_event == mllt_pkg::EV_START
		|-> rsp.status == mllt_pkg::STAT_LIMIT)
		else $error("alarm start without limit reached");

	// Rejected requests update no entry and report zero counters.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == mllt_pkg::STAT_RANGE
			|| rsp.status == mllt_pkg::STAT_NOT_VLAN)
		|-> rsp.learned_count == 8'd0 && rsp.attempt_total == 16'd0
			&& rsp.alarm_event == mllt_pkg::EV_NONE)
		else $error("rejected request reported entry data");

endmodule

`default_nettype wire

@@ hdl/mllt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mllt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/mllt_ctrl.sv @@
// Controller: clearing pass after reset, then accept / execute sequencing.
// Depends on mllt_pkg.
`default_nettype none

module mllt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output      logic                  req_ready,
	input  wire mllt_pkg::dp_stat_t    stat,
	output      mllt_pkg::ctrl_cmd_t   cmd
);

	localparam logic [mllt_pkg::RAM_AW-1:0] CLR_LAST =
		mllt_pkg::RAM_AW'(mllt_pkg::RAM_DEPTH - 1);

	mllt_pkg::ctrl_state_t state_q, state_d;
	logic [mllt_pkg::RAM_AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mllt_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mllt_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		cmd.clear    = 1'b0;
		cmd.clr_addr = clr_cnt_q;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		case (state_q)
			mllt_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (clr_cnt_q == CLR_LAST) begin
					state_d = mllt_pkg::ST_IDLE;
				end
			end
			mllt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = mllt_pkg::ST_EXEC;
				end
			end
			mllt_pkg::ST_EXEC: begin
				// hold until the output register has room
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = mllt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mllt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/mllt_dp.sv @@
// Datapath: entry RAM, captured request, entry update and output register.
// Depends on mllt_pkg and mllt_ram.
`default_nettype none

module mllt_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mllt_pkg::req_t      req,
	input  wire mllt_pkg::ctrl_cmd_t cmd,
	output      mllt_pkg::dp_stat_t  stat,
	output      logic                rsp_valid,
	input  wire logic                rsp_ready,
	output      mllt_pkg::rsp_t      rsp
);

	mllt_pkg::req_t   item_q;
	mllt_pkg::entry_t cur;
	mllt_pkg::entry_t nxt;
	mllt_pkg::rsp_t   res;
	mllt_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;
	logic             upd;
	logic [mllt_pkg::ENTRY_W-1:0] rdata;

	logic                        ram_we;
	logic [mllt_pkg::RAM_AW-1:0] ram_waddr;
	logic [mllt_pkg::ENTRY_W-1:0] ram_wdata;

	assign cur = mllt_pkg::entry_t'(rdata);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
	end

	always_comb begin
		nxt = cur;
		upd = 1'b0;
		res = '0;
		res.status         = mllt_pkg::STAT_OK;
		res.learn_mode_cmd = mllt_pkg::MODE_NONE;
		res.alarm_event    = mllt_pkg::EV_NONE;
		if (item_q.action != mllt_pkg::ACT_FLUSH
				&& (item_q.action inside {[mllt_pkg::ACT_LEARN:mllt_pkg::ACT_SETUP]})
				&& !item_q.is_vlan_port) begin
			res.status = mllt_pkg::STAT_NOT_VLAN;
		end else if (item_q.vp_index > 16'(mllt_pkg::MAX_VPORT_INDEX)) begin
			res.status = mllt_pkg::STAT_RANGE;
		end else begin
			upd = 1'b1;
			case (item_q.action)
				mllt_pkg::ACT_LEARN: begin
					if (cur.limit == mllt_pkg::NO_LIMIT) begin
						res.status = mllt_pkg::STAT_DISABLED;
					end else if (cur.learned >= cur.limit) begin
						nxt.total = cur.total + 16'd1;
						if (!cur.raised) begin
							res.alarm_event = mllt_pkg::EV_START;
							res.alarm_intf  = cur.intf;
							res.alarm_vid   = cur.vid;
							nxt.raised      = 1'b1;
						end
						res.status = mllt_pkg::STAT_LIMIT;
					end else begin
						nxt.learned = cur.learned + 8'd1;
						nxt.total   = cur.total + 16'd1;
						if (nxt.learned >= cur.limit) begin
							res.learn_mode_cmd = mllt_pkg::MODE_PEND_NO_FWD;
						end
					end
				end
				mllt_pkg::ACT_AGE: begin
					if (cur.limit == mllt_pkg::NO_LIMIT) begin
						res.status = mllt_pkg::STAT_DISABLED;
					end else if (item_q.pending_flag && !item_q.move_flag) begin
						if (cur.total > {8'd0, cur.learned} && cur.total != 16'd0) begin
							nxt.total = cur.total - 16'd1;
						end
						res.status = mllt_pkg::STAT_PENDING;
					end else begin
						if (cur.learned != 8'd0) begin
							nxt.learned = cur.learned - 8'd1;
							nxt.total   = cur.total - 16'd1;
						end
						if (nxt.learned <= cur.limit && cur.raised) begin
							res.alarm_event = mllt_pkg::EV_END;
							res.alarm_intf  = cur.intf;
							res.alarm_vid   = cur.vid;
							nxt.raised      = 1'b0;
						end
					end
				end
				mllt_pkg::ACT_SETLIM, mllt_pkg::ACT_RESET: begin
					if (item_q.action == mllt_pkg::ACT_SETLIM
							&& item_q.new_limit != mllt_pkg::NO_LIMIT) begin
						nxt.limit = item_q.new_limit;
						res.learn_mode_cmd = (cur.learned >= item_q.new_limit) ?
							mllt_pkg::MODE_PEND_NO_FWD : mllt_pkg::MODE_PEND_FWD;
					end else if (item_q.action == mllt_pkg::ACT_RESET
							|| cur.limit != mllt_pkg::NO_LIMIT) begin
						// entry reset: clear counters, drop limit, end any alarm
						res.learn_mode_cmd = mllt_pkg::MODE_FWD_ONLY;
						nxt.learned = 8'd0;
						nxt.total   = 16'd0;
						nxt.limit   = mllt_pkg::NO_LIMIT;
						if (cur.raised) begin
							res.alarm_event = mllt_pkg::EV_END;
							res.alarm_intf  = cur.intf;
							res.alarm_vid   = cur.vid;
							nxt.raised      = 1'b0;
						end
					end
				end
				mllt_pkg::ACT_FLUSH: begin
					nxt.total   = cur.total - {8'd0, cur.learned};
					nxt.learned = 8'd0;
				end
				mllt_pkg::ACT_SETUP: begin
					nxt.intf = item_q.intf_id;
					nxt.vid  = item_q.tag_vid;
				end
				default: begin
				end
			endcase
			res.learned_count = nxt.learned;
			res.attempt_total = nxt.total;
		end
	end

	// clearing pass has the write port to itself; otherwise write back
	always_comb begin
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = cmd.clr_addr;
			ram_wdata = mllt_pkg::ENTRY_RESET;
		end else begin
			ram_we    = cmd.exec && upd;
			ram_waddr = item_q.vp_index[mllt_pkg::RAM_AW-1:0];
			ram_wdata = nxt;
		end
	end

	mllt_ram #(
		.WIDTH(mllt_pkg::ENTRY_W),
		.DEPTH(mllt_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(req.vp_index[mllt_pkg::RAM_AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= res;
		end
	end

	assign stat.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

`default_nettype wire
